FILE: sv/mapid_pkg.sv
// Shared types and constants for the multi-axis PID position loop.
// No dependencies; imported by every module of the block.
package mapid_pkg;

    // register indexes on the configuration port (byte address = 4 * index)
    localparam logic [2:0] REG_GAIN_P         = 3'd0;
    localparam logic [2:0] REG_GAIN_I         = 3'd1;
    localparam logic [2:0] REG_GAIN_D         = 3'd2;
    localparam logic [2:0] REG_STEP_PERIOD    = 3'd3;
    localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [2:0] REG_ACCURACY_BAND  = 3'd5;

    localparam logic [15:0] GAIN_P_RST         = 16'd256;
    localparam logic [15:0] GAIN_I_RST         = 16'd0;
    localparam logic [15:0] GAIN_D_RST         = 16'd0;
    localparam logic [15:0] STEP_PERIOD_RST    = 16'd655;
    localparam logic [30:0] INTEGRAL_LIMIT_RST = 31'd655360;
    localparam logic [30:0] ACCURACY_BAND_RST  = 31'd6554;

    // integral separation: 10 degrees in Q15.16
    localparam logic signed [32:0] SEP_LIMIT = 33'sd655360;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [15:0] step_period;
        logic [30:0] integral_limit;
        logic [30:0] accuracy_band;
    } mapid_cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_BAND,
        S_IMUL,
        S_IADD,
        S_ICLAMP,
        S_MULP,
        S_MULI,
        S_MULD,
        S_ACCD,
        S_SAT,
        S_DONE
    } mapid_state_t;

endpackage

FILE: sv/mapid_mul.sv
// Shared signed multiplier with registered product.
// Depends on mapid_pkg for operand widths.
module mapid_mul
(
    input  logic                                  clk,
    input  logic signed [mapid_pkg::MUL_A_W-1:0]  a,
    input  logic signed [mapid_pkg::MUL_B_W-1:0]  b,
    output logic signed [mapid_pkg::PROD_W-1:0]   prod
);
    import mapid_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: sv/mapid_cfg.sv
// APB-style register file holding gains, step, integral clamp and band.
// Depends on mapid_pkg for register indexes, reset values and mapid_cfg_t.
module mapid_cfg
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output mapid_pkg::mapid_cfg_t   cfg
);
    import mapid_pkg::*;

    mapid_cfg_t cfg_reg;
    mapid_cfg_t cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_GAIN_P:         cfg_next.gain_p         = pwdata[15:0];
                REG_GAIN_I:         cfg_next.gain_i         = pwdata[15:0];
                REG_GAIN_D:         cfg_next.gain_d         = pwdata[15:0];
                REG_STEP_PERIOD:    cfg_next.step_period    = pwdata[15:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = pwdata[30:0];
                REG_ACCURACY_BAND:  cfg_next.accuracy_band  = pwdata[30:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_GAIN_P:         prdata = {16'd0, cfg_reg.gain_p};
            REG_GAIN_I:         prdata = {16'd0, cfg_reg.gain_i};
            REG_GAIN_D:         prdata = {16'd0, cfg_reg.gain_d};
            REG_STEP_PERIOD:    prdata = {16'd0, cfg_reg.step_period};
            REG_INTEGRAL_LIMIT: prdata = {1'b0, cfg_reg.integral_limit};
            REG_ACCURACY_BAND:  prdata = {1'b0, cfg_reg.accuracy_band};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= GAIN_P_RST;
            cfg_reg.gain_i         <= GAIN_I_RST;
            cfg_reg.gain_d         <= GAIN_D_RST;
            cfg_reg.step_period    <= STEP_PERIOD_RST;
            cfg_reg.integral_limit <= INTEGRAL_LIMIT_RST;
            cfg_reg.accuracy_band  <= ACCURACY_BAND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/multi_axis_pid_position_loop.sv
// Multi-axis PID position loop: one beat in, one beat out, single shared multiplier.
// The integral update adds states inside the integration window; an axis number out of range
// goes from the error state straight to the result.
// One item at a time: the input stalls until the result is registered.
// A stalled output holds the finished item in S_DONE.
// Reset loads the register defaults and clears every axis integral and previous error.
module multi_axis_pid_position_loop
#(
    parameter int AXES = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         axis,
    input  logic signed [31:0] target_angle,
    input  logic signed [31:0] measured_angle,
    input  logic [30:0]        speed_limit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         axis_out,
    output logic signed [31:0] speed_command,
    output logic               stop_axis
);
    import mapid_pkg::*;

    localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

    mapid_cfg_t cfg;

    mapid_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mapid_state_t state_reg, state_next;

    logic [2:0]               axis_reg, axis_next;
    logic signed [31:0]       tgt_reg, tgt_next;
    logic signed [31:0]       meas_reg, meas_next;
    logic [30:0]              sl_reg, sl_next;
    logic signed [31:0]       e_reg, e_next;
    logic signed [31:0]       last_reg, last_next;
    logic signed [31:0]       integ_reg, integ_next;
    logic signed [33:0]       isum_reg, isum_next;
    logic signed [ACC_W-1:0]  accum_reg, accum_next;
    logic signed [31:0]       u_reg, u_next;
    logic                     stop_reg, stop_next;

    logic                     out_valid_reg, out_valid_next;
    logic [2:0]               axis_out_reg, axis_out_next;
    logic signed [31:0]       speed_reg, speed_next;
    logic                     stop_out_reg, stop_out_next;

    logic signed [31:0]       integ_mem_reg [AXES];
    logic signed [31:0]       prev_mem_reg [AXES];
    logic                     integ_we;
    logic                     prev_we;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    mapid_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // per-axis index
    logic [31:0]    axis_wide;
    logic [AXW-1:0] idx;
    logic           in_range;

    assign axis_wide = 32'(axis_reg);
    assign idx       = axis_wide[AXW-1:0];
    assign in_range  = axis_wide < AXES;

    // error with saturation to 32 bits
    logic signed [32:0] diff33;
    logic signed [31:0] err_sat;
    assign diff33  = {tgt_reg[31], tgt_reg} - {meas_reg[31], meas_reg};
    assign err_sat = (diff33[32] != diff33[31])
                   ? (diff33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                   : diff33[31:0];

    // band and integration window checks
    logic signed [32:0] e33;
    logic signed [32:0] band33;
    logic               in_band;
    logic               in_window;
    assign e33       = {e_reg[31], e_reg};
    assign band33    = {2'b00, cfg.accuracy_band};
    assign in_band   = (e33 > -band33) && (e33 < band33);
    assign in_window = in_band || ((e33 > -SEP_LIMIT) && (e33 < SEP_LIMIT));

    // integral clamp
    logic signed [33:0] lim34;
    logic signed [33:0] isum_clamped;
    assign lim34        = {3'b000, cfg.integral_limit};
    assign isum_clamped = (isum_reg > lim34) ? lim34
                        : ((isum_reg < -lim34) ? -lim34 : isum_reg);

    // output saturation, floor shift by 8 is an arithmetic shift
    logic signed [ACC_W-9:0] u_shift;
    logic signed [ACC_W-9:0] sl_wide;
    logic signed [ACC_W-9:0] u_sat;
    logic signed [ACC_W-1:0] prod_ext;
    assign u_shift  = accum_reg[ACC_W-1:8];
    assign sl_wide  = (ACC_W-8)'(sl_reg);
    assign u_sat    = (u_shift >= sl_wide) ? sl_wide
                    : ((u_shift < -sl_wide) ? -sl_wide : u_shift);
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_IMUL:
            begin
                mul_a = {e_reg[31], e_reg};
                mul_b = {1'b0, cfg.step_period};
            end
            S_MULI:
            begin
                mul_a = {integ_reg[31], integ_reg};
                mul_b = {1'b0, cfg.gain_i};
            end
            S_MULD:
            begin
                mul_a = {e_reg[31], e_reg} - {last_reg[31], last_reg};
                mul_b = {1'b0, cfg.gain_d};
            end
            default:
            begin
                mul_a = {e_reg[31], e_reg};
                mul_b = {1'b0, cfg.gain_p};
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        tgt_next       = tgt_reg;
        meas_next      = meas_reg;
        sl_next        = sl_reg;
        e_next         = e_reg;
        last_next      = last_reg;
        integ_next     = integ_reg;
        isum_next      = isum_reg;
        accum_next     = accum_reg;
        u_next         = u_reg;
        stop_next      = stop_reg;
        out_valid_next = out_valid_reg && out_stall;
        axis_out_next  = axis_out_reg;
        speed_next     = speed_reg;
        stop_out_next  = stop_out_reg;
        integ_we       = 1'b0;
        prev_we        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    axis_next  = axis;
                    tgt_next   = target_angle;
                    meas_next  = measured_angle;
                    sl_next    = speed_limit;
                    u_next     = 32'sd0;
                    stop_next  = 1'b0;
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                e_next = err_sat;
                if (in_range)
                begin
                    last_next  = prev_mem_reg[idx];
                    integ_next = integ_mem_reg[idx];
                    state_next = S_BAND;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BAND:
            begin
                if (in_band)
                begin
                    e_next    = 32'sd0;
                    last_next = 32'sd0;
                    stop_next = 1'b1;
                end
                state_next = in_window ? S_IMUL : S_MULP;
            end
            S_IMUL:
            begin
                state_next = S_IADD;
            end
            S_IADD:
            begin
                // floor(e * step / 2^16) by dropping the low product bits
                isum_next  = {{2{integ_reg[31]}}, integ_reg} + prod[PROD_W-1:16];
                state_next = S_ICLAMP;
            end
            S_ICLAMP:
            begin
                integ_next = isum_clamped[31:0];
                integ_we   = 1'b1;
                state_next = S_MULI;
            end
            S_MULP:
            begin
                state_next = S_MULI;
            end
            S_MULI:
            begin
                accum_next = prod_ext;
                state_next = S_MULD;
            end
            S_MULD:
            begin
                accum_next = accum_reg + prod_ext;
                state_next = S_ACCD;
            end
            S_ACCD:
            begin
                accum_next = accum_reg + prod_ext;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                u_next     = stop_reg ? 32'sd0 : u_sat[31:0];
                prev_we    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    axis_out_next  = axis_reg;
                    speed_next     = u_reg;
                    stop_out_next  = stop_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg     <= axis_next;
        tgt_reg      <= tgt_next;
        meas_reg     <= meas_next;
        sl_reg       <= sl_next;
        e_reg        <= e_next;
        last_reg     <= last_next;
        integ_reg    <= integ_next;
        isum_reg     <= isum_next;
        accum_reg    <= accum_next;
        u_reg        <= u_next;
        stop_reg     <= stop_next;
        axis_out_reg <= axis_out_next;
        speed_reg    <= speed_next;
        stop_out_reg <= stop_out_next;
    end

    // per-axis state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                integ_mem_reg[k] <= 32'sd0;
                prev_mem_reg[k]  <= 32'sd0;
            end
        end
        else
        begin
            if (integ_we)
            begin
                integ_mem_reg[idx] <= integ_next;
            end
            if (prev_we)
            begin
                prev_mem_reg[idx] <= e_reg;
            end
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign axis_out      = axis_out_reg;
    assign speed_command = speed_reg;
    assign stop_axis     = stop_out_reg;

    // an accepted beat blocks the input until its result is registered
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while previous item still in flight");

    a_stop_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stop_axis) |-> (speed_command == 32'sd0))
        else $error("stopped axis with nonzero speed command");

    a_bad_axis_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (32'(axis_out) >= AXES)) |-> ((speed_command == 32'sd0) && !stop_axis))
        else $error("out of range axis produced a command");

    a_speed_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |->
            ((u_reg <= $signed({1'b0, sl_reg})) && (u_reg >= -$signed({1'b0, sl_reg}))))
        else $error("speed command beyond speed limit");

endmodule

FILE: sim/multi_axis_pid_position_loop_test.sv
// Self-checking testbench for multi_axis_pid_position_loop: directed edge cases, then random
// phases under varying register settings, checked against an in-bench PID predictor.
// Depends on mapid_pkg and the multi_axis_pid_position_loop RTL.
module multi_axis_pid_position_loop_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mapid_pkg::*;

    localparam int     AXES        = 6;
    localparam int     CYCLE_LIMIT = 500000;
    localparam longint INT32_MAX   = 64'sd2147483647;
    localparam longint INT32_MIN   = -64'sd2147483648;
    localparam longint SEPARATION  = 64'sd655360;   // 10 deg, Q15.16
    localparam longint DEG         = 64'sd65536;
    localparam logic [30:0] SPEED_MAX = 31'h7FFFFFFF;

    typedef struct {
        logic [2:0]         axis;
        logic signed [31:0] target;
        logic signed [31:0] measured;
        logic [30:0]        limit;
    } pid_sample_t;

    typedef struct {
        logic [2:0]         axis;
        logic signed [31:0] speed;
        logic               stop;
    } pid_command_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         axis = '0;
    logic signed [31:0] target_angle = '0;
    logic signed [31:0] measured_angle = '0;
    logic [30:0]        speed_limit = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         axis_out;
    logic signed [31:0] speed_command;
    logic               stop_axis;

    // register shadow and per-axis loop state of the predictor
    logic [15:0]        cfg_gain_p = GAIN_P_RST;
    logic [15:0]        cfg_gain_i = GAIN_I_RST;
    logic [15:0]        cfg_gain_d = GAIN_D_RST;
    logic [15:0]        cfg_step = STEP_PERIOD_RST;
    logic [30:0]        cfg_integral_limit = INTEGRAL_LIMIT_RST;
    logic [30:0]        cfg_accuracy_band = ACCURACY_BAND_RST;
    logic signed [31:0] axis_integral [AXES];
    logic signed [31:0] axis_last_error [AXES];

    pid_command_t pending_commands[$];
    int           failures = 0;
    int           cycle_count = 0;
    bit           idle_on = 1'b1;
    int           stall_left = 0;

    multi_axis_pid_position_loop #(.AXES(AXES)) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .axis           (axis),
        .target_angle   (target_angle),
        .measured_angle (measured_angle),
        .speed_limit    (speed_limit),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .axis_out       (axis_out),
        .speed_command  (speed_command),
        .stop_axis      (stop_axis)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // random output back-pressure in bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 6) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_command
        pid_command_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_commands.size() == 0)
            begin
                $error("unexpected result beat: axis_out %0d speed_command %0d", axis_out,
                       speed_command);
                failures++;
            end
            else
            begin
                want = pending_commands.pop_front();
                if (axis_out !== want.axis)
                begin
                    $error("axis_out expected %0d got %0d", want.axis, axis_out);
                    failures++;
                end
                if (speed_command !== want.speed)
                begin
                    $error("speed_command expected %0d got %0d", want.speed, speed_command);
                    failures++;
                end
                if (stop_axis !== want.stop)
                begin
                    $error("stop_axis expected %0b got %0b", want.stop, stop_axis);
                    failures++;
                end
            end
        end
    end

    function automatic pid_command_t compute_speed_command(input pid_sample_t s);
        pid_command_t r;
        longint err, last, acc, u, band, lim, vmax;
        logic stop;
        r.axis  = s.axis;
        r.speed = '0;
        r.stop  = 1'b0;
        if (s.axis >= AXES)
            return r;
        stop = 1'b0;
        err = longint'(s.target) - longint'(s.measured);
        if (err > INT32_MAX)
            err = INT32_MAX;
        if (err < INT32_MIN)
            err = INT32_MIN;
        band = longint'(cfg_accuracy_band);
        lim  = longint'(cfg_integral_limit);
        vmax = longint'(s.limit);
        last = longint'(axis_last_error[s.axis]);
        if (err > -band && err < band)
        begin
            err  = 0;
            last = 0;
            stop = 1'b1;
        end
        acc = longint'(axis_integral[s.axis]);
        // integral separation: no update and no clamp outside +-10 deg
        if (err > -SEPARATION && err < SEPARATION)
        begin
            acc = acc + ((err * longint'(cfg_step)) >>> 16);
            if (acc > lim)
                acc = lim;
            if (acc < -lim)
                acc = -lim;
            axis_integral[s.axis] = acc[31:0];
        end
        u = (longint'(cfg_gain_p) * err + longint'(cfg_gain_i) * acc
             + longint'(cfg_gain_d) * (err - last)) >>> 8;
        if (u >= vmax)
            u = vmax;
        else if (u < -vmax)
            u = -vmax;
        axis_last_error[s.axis] = err[31:0];
        if (stop)
            r.stop = 1'b1;
        else
            r.speed = u[31:0];
        return r;
    endfunction

    function automatic pid_sample_t sample_of(input logic [2:0] ax, input longint tgt,
                                              input longint meas, input logic [30:0] vmax);
        pid_sample_t s;
        s.axis     = ax;
        s.target   = tgt[31:0];
        s.measured = meas[31:0];
        s.limit    = vmax;
        return s;
    endfunction

    // mostly small errors around the band and the 10 deg window, some fully random angles
    function automatic pid_sample_t make_position_sample();
        pid_sample_t s;
        longint err, tgt, meas;
        int pick;
        pick = $urandom_range(0, 19);
        if ($urandom_range(0, 9) == 0)
            s.axis = 3'($urandom_range(AXES, 7));
        else
            s.axis = 3'($urandom_range(0, AXES - 1));
        tgt = longint'($signed($urandom));
        if (pick >= 16)
        begin
            meas = longint'($signed($urandom));
        end
        else
        begin
            if (pick < 10)
                err = longint'($urandom_range(0, 24 * 65536)) - 12 * DEG;
            else if (pick < 13)
                err = longint'(cfg_accuracy_band) + longint'($urandom_range(0, 4)) - 2;
            else
                err = SEPARATION + longint'($urandom_range(0, 4)) - 2;
            if (pick >= 10 && $urandom_range(0, 1) == 1)
                err = -err;
            if (err > INT32_MAX)
                err = INT32_MAX;
            if (err < INT32_MIN)
                err = INT32_MIN;
            meas = tgt - err;
            if (meas > INT32_MAX || meas < INT32_MIN)
                meas = tgt + err;
        end
        s.target   = tgt[31:0];
        s.measured = meas[31:0];
        case ($urandom_range(0, 9))
            0, 1:    s.limit = 31'($urandom_range(0, 255));
            2, 3, 4: s.limit = 31'($urandom);
            default: s.limit = 31'($urandom_range(0, 20 * 65536));
        endcase
        return s;
    endfunction

    task automatic send_sample(input pid_sample_t s);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        axis           <= s.axis;
        target_angle   <= s.target;
        measured_angle <= s.measured;
        speed_limit    <= s.limit;
        do @(posedge clk); while (in_stall);
        pending_commands.push_back(compute_speed_command(s));
    endtask

    task automatic wait_all_commands();
        in_valid <= 1'b0;
        while (pending_commands.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIN_P:         cfg_gain_p = value[15:0];
            REG_GAIN_I:         cfg_gain_i = value[15:0];
            REG_GAIN_D:         cfg_gain_d = value[15:0];
            REG_STEP_PERIOD:    cfg_step = value[15:0];
            REG_INTEGRAL_LIMIT: cfg_integral_limit = value[30:0];
            REG_ACCURACY_BAND:  cfg_accuracy_band = value[30:0];
            default: ;
        endcase
        // idle the bus between transfers
        @(posedge clk);
    endtask

    task automatic load_config(input logic [15:0] gp, input logic [15:0] gi,
                               input logic [15:0] gd, input logic [15:0] step,
                               input logic [30:0] ilim, input logic [30:0] band);
        wait_all_commands();
        write_register(REG_GAIN_P, {16'd0, gp});
        write_register(REG_GAIN_I, {16'd0, gi});
        write_register(REG_GAIN_D, {16'd0, gd});
        write_register(REG_STEP_PERIOD, {16'd0, step});
        write_register(REG_INTEGRAL_LIMIT, {1'b0, ilim});
        write_register(REG_ACCURACY_BAND, {1'b0, band});
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 1023));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // reset defaults: band edges, 10 deg window edges, angle overflow, limits, bad axes
    task automatic test_default_edges();
        send_sample(sample_of(3'd0, 0, 0, SPEED_MAX));
        send_sample(sample_of(3'd0, 6553, 0, SPEED_MAX));
        send_sample(sample_of(3'd0, 6554, 0, SPEED_MAX));
        send_sample(sample_of(3'd0, -6553, 0, SPEED_MAX));
        send_sample(sample_of(3'd0, 0, 6554, SPEED_MAX));
        send_sample(sample_of(3'd1, 655359, 0, SPEED_MAX));
        send_sample(sample_of(3'd1, 655360, 0, SPEED_MAX));
        send_sample(sample_of(3'd1, 0, 655359, SPEED_MAX));
        send_sample(sample_of(3'd1, -655360, 0, SPEED_MAX));
        send_sample(sample_of(3'd2, INT32_MAX, INT32_MIN, SPEED_MAX));
        send_sample(sample_of(3'd2, INT32_MIN, INT32_MAX, SPEED_MAX));
        send_sample(sample_of(3'd2, INT32_MAX, INT32_MIN, 31'd12345));
        send_sample(sample_of(3'd3, 5 * DEG, 0, 31'd0));
        send_sample(sample_of(3'd3, -5 * DEG, 0, 31'd0));
        send_sample(sample_of(3'd3, -5 * DEG, 0, 31'd65536));
        send_sample(sample_of(3'd3, 5 * DEG, 0, 31'd65536));
        send_sample(sample_of(3'd4, DEG, 0, SPEED_MAX));
        send_sample(sample_of(3'd5, -DEG, 3 * DEG, SPEED_MAX));
        send_sample(sample_of(3'd6, INT32_MAX, 0, SPEED_MAX));
        send_sample(sample_of(3'd7, INT32_MIN, INT32_MAX, 31'd7));
        send_sample(sample_of(3'd4, 2 * DEG, DEG, SPEED_MAX));
        send_sample(sample_of(3'd5, 0, 0, SPEED_MAX));
    endtask

    // integral term alone, driven into its clamp from both sides
    task automatic test_integral_windup();
        int k;
        longint err;
        load_config(16'd0, 16'd2048, 16'd0, 16'hFFFF, 31'(3 * 65536), 31'd0);
        for (k = 0; k < 40; k++)
        begin
            err = longint'($urandom_range(5 * 65536, 655359));
            if (k >= 20)
                err = -err;
            send_sample(sample_of((k % 2 == 0) ? 3'd2 : 3'd5, err, 0, SPEED_MAX));
        end
    endtask

    task automatic test_gain_extremes();
        int k;
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, SPEED_MAX, 31'd0);
        for (k = 0; k < 60; k++)
            send_sample(make_position_sample());
    endtask

    // widest band: nearly everything stops except saturated errors
    task automatic test_band_extremes();
        int k;
        load_config(16'd0, 16'd0, 16'd0, 16'd0, 31'd0, SPEED_MAX);
        for (k = 0; k < 40; k++)
            send_sample(make_position_sample());
        send_sample(sample_of(3'd1, INT32_MAX, INT32_MIN, SPEED_MAX));
    endtask

    task automatic test_random_phases();
        int phase, k, pause_at;
        logic [15:0] step;
        logic [30:0] ilim, band;
        for (phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 3))
                0:       step = 16'd0;
                1:       step = 16'hFFFF;
                default: step = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       ilim = 31'd0;
                1:       ilim = SPEED_MAX;
                default: ilim = 31'($urandom_range(0, 30 * 65536));
            endcase
            band = ($urandom_range(0, 3) == 0) ? 31'd0 : 31'($urandom_range(0, 2 * 65536));
            load_config(pick_gain(), pick_gain(), pick_gain(), step, ilim, band);
            idle_on  = (phase == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
            pause_at = $urandom_range(20, 200);
            for (k = 0; k < 225; k++)
            begin
                if (k == pause_at)
                    wait_all_commands();
                send_sample(make_position_sample());
            end
        end
    endtask

    initial
    begin
        int k;
        for (k = 0; k < AXES; k++)
        begin
            axis_integral[k]   = '0;
            axis_last_error[k] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_edges();
        test_integral_windup();
        test_gain_extremes();
        test_band_extremes();
        test_random_phases();

        wait_all_commands();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
